### rtl/assert_macros.svh
// assertion macros shared by the frame interval averager modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define FIA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define FIA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/fia_pkg.sv
// types, constants and command structs for the frame interval averager
package fia_pkg;

   localparam int WINDOW_DEPTH = 64;
   localparam int PTR_W        = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W        = 32 + $clog2(WINDOW_DEPTH);
   localparam int DIV_CNT_W    = $clog2(SUM_W + 1);
   localparam logic [31:0] TPS_RESET = 32'd10000000;

   typedef enum logic [1:0] {
      FUNC_MARK  = 2'd0,
      FUNC_STOP  = 2'd1,
      FUNC_START = 2'd2,
      FUNC_RESET = 2'd3
   } fia_func_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic measure;
      logic clear_avg;
      logic do_stop;
      logic do_start;
      logic add_paused;
      logic do_reset;
      logic check;
      logic rate_add;
      logic rate_latch;
      logic drop;
      logic push;
      logic div_load;
      logic div_step;
      logic avg_load;
      logic total;
      logic respond;
   } fia_cmd_type;

   // datapath to controller
   typedef struct packed {
      fia_func_type func;
      logic         stopped;
      logic         keep;
      logic         full;
      logic         count_zero;
      logic         div_last;
      logic         rsp_free;
   } fia_sts_type;

endpackage

### rtl/fia_ctrl.sv
// sequencing state machine for the frame interval averager
`include "assert_macros.svh"

module fia_ctrl
   import fia_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  fia_sts_type sts,
   output fia_cmd_type cmd
);

   typedef enum logic [12:0] {
      ST_IDLE      = 13'h0001,
      ST_DECODE    = 13'h0002,
      ST_START_ADD = 13'h0004,
      ST_CHECK     = 13'h0008,
      ST_RATE      = 13'h0010,
      ST_LATCH     = 13'h0020,
      ST_DROP      = 13'h0040,
      ST_PUSH      = 13'h0080,
      ST_DIV_LOAD  = 13'h0100,
      ST_DIV_STEP  = 13'h0200,
      ST_AVG_LOAD  = 13'h0400,
      ST_TOTAL     = 13'h0800,
      ST_DONE      = 13'h1000
   } fia_state_type;

   fia_state_type state_ff, state_in;

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            unique case (sts.func)
               FUNC_MARK: begin
                  if (sts.stopped) begin
                     cmd.clear_avg = 1'b1;
                     state_in      = ST_TOTAL;
                  end else begin
                     cmd.measure = 1'b1;
                     state_in    = ST_CHECK;
                  end
               end
               FUNC_STOP: begin
                  cmd.do_stop = !sts.stopped;
                  state_in    = ST_TOTAL;
               end
               FUNC_START: begin
                  if (sts.stopped) begin
                     cmd.do_start = 1'b1;
                     state_in     = ST_START_ADD;
                  end else begin
                     state_in = ST_TOTAL;
                  end
               end
               FUNC_RESET: begin
                  cmd.do_reset = 1'b1;
                  state_in     = ST_TOTAL;
               end
               default: state_in = ST_TOTAL;
            endcase
         end
         ST_START_ADD: begin
            cmd.add_paused = 1'b1;
            state_in       = ST_TOTAL;
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = ST_RATE;
         end
         ST_RATE: begin
            cmd.rate_add = 1'b1;
            state_in     = ST_LATCH;
         end
         ST_LATCH: begin
            cmd.rate_latch = 1'b1;
            priority if (sts.keep && sts.full) state_in = ST_DROP;
            else if (sts.keep)                 state_in = ST_PUSH;
            else                               state_in = ST_DIV_LOAD;
         end
         ST_DROP: begin
            cmd.drop = 1'b1;
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            cmd.push = 1'b1;
            state_in = ST_DIV_LOAD;
         end
         ST_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = sts.count_zero ? ST_TOTAL : ST_DIV_STEP;
         end
         ST_DIV_STEP: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = ST_AVG_LOAD;
         end
         ST_AVG_LOAD: begin
            cmd.avg_load = 1'b1;
            state_in     = ST_TOTAL;
         end
         ST_TOTAL: begin
            cmd.total = 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (sts.rsp_free) begin
               cmd.respond = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `FIA_ASSERT_IMPL(a_respond_free, clock, reset, cmd.respond, sts.rsp_free, "result loaded over a waiting one")
   `FIA_ASSERT_NEXT(a_div_finish, clock, reset, (state_ff == ST_DIV_STEP) && sts.div_last, state_ff == ST_AVG_LOAD, "divide did not finish")

endmodule

### rtl/fia_dpath.sv
// datapath: marks, interval window, rate counter, serial divider and result register
`include "assert_macros.svh"

module fia_dpath
   import fia_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_wr_en,
   input  logic [31:0]   csr_wr_data,
   input  logic [1:0]    req_func,
   input  logic [63:0]   req_timestamp,
   input  logic          rsp_tready,
   output logic          rsp_tvalid,
   output logic [31:0]   rsp_avg_frame_ticks,
   output logic [15:0]   rsp_frame_rate,
   output logic [63:0]   rsp_total_ticks,
   output logic          rsp_is_stopped,
   input  fia_cmd_type   cmd,
   output fia_sts_type   sts
);

   logic [31:0] window_mem [WINDOW_DEPTH];
   logic [31:0] rd_ff;

   fia_func_type         func_ff, func_in;
   logic [63:0]          ts_ff, ts_in;
   logic [63:0]          last_ff, last_in;
   logic [63:0]          cur_ff, cur_in;
   logic [63:0]          base_ff, base_in;
   logic [63:0]          stop_ff, stop_in;
   logic [63:0]          paused_ff, paused_in;
   logic                 stopped_ff, stopped_in;
   logic [63:0]          iv_ff, iv_in;
   logic                 keep_ff, keep_in;
   logic [15:0]          frames_ff, frames_in;
   logic [63:0]          rate_ff, rate_in;
   logic [15:0]          latched_ff, latched_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic [31:0]          avg_ff, avg_in;
   logic [PTR_W-1:0]     wp_ff, wp_in;
   logic [SUM_W-1:0]     quot_ff, quot_in;
   logic [CNT_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] divcnt_ff, divcnt_in;
   logic [63:0]          work_ff, work_in;
   logic [31:0]          tps_ff, tps_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [31:0]          rsp_avg_ff, rsp_avg_in;
   logic [15:0]          rsp_rate_ff, rsp_rate_in;
   logic [63:0]          rsp_total_ff, rsp_total_in;
   logic                 rsp_stop_ff, rsp_stop_in;

   logic              full;
   logic [31:0]       iv_sat;
   logic [63:0]       avg_ext;
   logic [63:0]       diff;
   logic [64:0]       rate_sum;
   logic [CNT_W:0]    trial;
   logic              trial_ge;

   assign full    = (count_ff == CNT_W'(WINDOW_DEPTH));
   assign iv_sat  = (|iv_ff[63:32]) ? 32'hFFFF_FFFF : iv_ff[31:0];
   assign avg_ext = {32'd0, avg_ff};
   assign diff    = (iv_ff >= avg_ext) ? (iv_ff - avg_ext) : (avg_ext - iv_ff);
   assign rate_sum = {1'b0, rate_ff} + {1'b0, iv_ff};
   assign trial    = {rem_ff, quot_ff[SUM_W-1]};
   assign trial_ge = (trial >= {1'b0, count_ff});

   always_comb begin
      func_in      = func_ff;
      ts_in        = ts_ff;
      last_in      = last_ff;
      cur_in       = cur_ff;
      base_in      = base_ff;
      stop_in      = stop_ff;
      paused_in    = paused_ff;
      stopped_in   = stopped_ff;
      iv_in        = iv_ff;
      keep_in      = keep_ff;
      frames_in    = frames_ff;
      rate_in      = rate_ff;
      latched_in   = latched_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      avg_in       = avg_ff;
      wp_in        = wp_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      divcnt_in    = divcnt_ff;
      work_in      = work_ff;
      tps_in       = csr_wr_en ? csr_wr_data : tps_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_avg_in   = rsp_avg_ff;
      rsp_rate_in  = rsp_rate_ff;
      rsp_total_in = rsp_total_ff;
      rsp_stop_in  = rsp_stop_ff;

      if (cmd.capture) begin
         func_in = fia_func_type'(req_func);
         ts_in   = req_timestamp;
      end
      if (cmd.measure) begin
         iv_in   = ts_ff - last_ff;
         last_in = ts_ff;
         cur_in  = ts_ff;
      end
      if (cmd.clear_avg) begin
         avg_in = '0;
      end
      if (cmd.do_stop) begin
         stop_in    = ts_ff;
         stopped_in = 1'b1;
      end
      if (cmd.do_start) begin
         work_in    = ts_ff - stop_ff;
         last_in    = ts_ff;
         cur_in     = ts_ff;
         stop_in    = '0;
         stopped_in = 1'b0;
      end
      if (cmd.add_paused) begin
         paused_in = paused_ff + work_ff;
      end
      if (cmd.do_reset) begin
         base_in    = ts_ff;
         last_in    = ts_ff;
         cur_in     = ts_ff;
         stop_in    = '0;
         paused_in  = '0;
         stopped_in = 1'b0;
      end
      if (cmd.check) begin
         keep_in = (diff < {32'd0, tps_ff});
         if (frames_ff != 16'hFFFF) frames_in = frames_ff + 16'd1;
      end
      if (cmd.rate_add) begin
         rate_in = rate_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : rate_sum[63:0];
      end
      if (cmd.rate_latch && (rate_ff > {32'd0, tps_ff})) begin
         latched_in = frames_ff;
         frames_in  = '0;
         rate_in    = '0;
      end
      if (cmd.drop) begin
         sum_in = sum_ff - SUM_W'(rd_ff);
      end
      if (cmd.push) begin
         sum_in = sum_ff + SUM_W'(iv_sat);
         wp_in  = (wp_ff == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_ff + PTR_W'(1);
         if (!full) count_in = count_ff + CNT_W'(1);
      end
      if (cmd.div_load) begin
         quot_in   = sum_ff;
         rem_in    = '0;
         divcnt_in = DIV_CNT_W'(SUM_W);
         if (count_ff == '0) avg_in = '0;
      end
      if (cmd.div_step) begin
         quot_in   = {quot_ff[SUM_W-2:0], trial_ge};
         rem_in    = trial_ge ? CNT_W'(trial - {1'b0, count_ff}) : trial[CNT_W-1:0];
         divcnt_in = divcnt_ff - DIV_CNT_W'(1);
      end
      if (cmd.avg_load) begin
         avg_in = quot_ff[31:0];
      end
      if (cmd.total) begin
         work_in = (stopped_ff ? stop_ff : cur_ff) - paused_ff;
      end
      if (cmd.respond) begin
         rsp_valid_in = 1'b1;
         rsp_avg_in   = stopped_ff ? 32'd0 : avg_ff;
         rsp_rate_in  = latched_ff;
         rsp_total_in = work_ff - base_ff;
         rsp_stop_in  = stopped_ff;
      end
   end

   // window store, oldest entry on the read port once the window is full
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         window_mem[wp_ff] <= iv_sat;
      end
      rd_ff <= window_mem[wp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= '0;
         cur_ff       <= '0;
         base_ff      <= '0;
         stop_ff      <= '0;
         paused_ff    <= '0;
         stopped_ff   <= 1'b0;
         frames_ff    <= '0;
         rate_ff      <= '0;
         latched_ff   <= '0;
         count_ff     <= '0;
         sum_ff       <= '0;
         avg_ff       <= '0;
         wp_ff        <= '0;
         keep_ff      <= 1'b0;
         divcnt_ff    <= '0;
         tps_ff       <= TPS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_ff      <= last_in;
         cur_ff       <= cur_in;
         base_ff      <= base_in;
         stop_ff      <= stop_in;
         paused_ff    <= paused_in;
         stopped_ff   <= stopped_in;
         frames_ff    <= frames_in;
         rate_ff      <= rate_in;
         latched_ff   <= latched_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         avg_ff       <= avg_in;
         wp_ff        <= wp_in;
         keep_ff      <= keep_in;
         divcnt_ff    <= divcnt_in;
         tps_ff       <= tps_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff      <= func_in;
      ts_ff        <= ts_in;
      iv_ff        <= iv_in;
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      work_ff      <= work_in;
      rsp_avg_ff   <= rsp_avg_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_total_ff <= rsp_total_in;
      rsp_stop_ff  <= rsp_stop_in;
   end

   assign sts.func       = func_ff;
   assign sts.stopped    = stopped_ff;
   assign sts.keep       = keep_ff;
   assign sts.full       = full;
   assign sts.count_zero = (count_ff == '0);
   assign sts.div_last   = (divcnt_ff == DIV_CNT_W'(1));
   assign sts.rsp_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid          = rsp_valid_ff;
   assign rsp_avg_frame_ticks = rsp_avg_ff;
   assign rsp_frame_rate      = rsp_rate_ff;
   assign rsp_total_ticks     = rsp_total_ff;
   assign rsp_is_stopped      = rsp_stop_ff;

   `FIA_ASSERT_IMPL(a_count_max, clock, reset, 1'b1, count_ff <= CNT_W'(WINDOW_DEPTH), "sample count beyond window depth")
   `FIA_ASSERT_NEXT(a_full_stays, clock, reset, cmd.push && full, count_ff == CNT_W'(WINDOW_DEPTH), "full window lost a sample")

endmodule

### rtl/frame_interval_averager_top.sv
// top level of the frame interval averager: controller plus datapath
//
//  channel   dir   payload
//  req_*     in    tuser = func, tdata = timestamp
//  rsp_*     out   tdata = avg / rate / total, tuser = is_stopped
//  csr_*     in    ticks_per_second, written on csr_wr_en
//
//  a running frame mark walks the 38-step bit-serial divide of the window sum after its
//  window update: a push of a kept interval, with a drop of the oldest entry first when full;
//  with an empty window and the interval rejected the divide is skipped
//  stop, reset, a running start and a stopped mark skip both; a start from stop adds a step
//  reset is synchronous; the window store is not cleared, the fill count guards it
//  a stalled result waits in the output register while the next item is taken;
//  only the final load of a result waits for that register to drain
module frame_interval_averager_top
   import fia_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   // configuration
   input  logic          csr_wr_en,
   input  logic [31:0]   csr_wr_data,   // ticks_per_second
   // request stream
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [63:0]   req_tdata,     // [63:0] timestamp
   input  logic [1:0]    req_tuser,     // [1:0] func
   // result stream
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [111:0]  rsp_tdata,     // [31:0] avg_frame_ticks, [47:32] frame_rate,
                                        // [111:48] total_ticks
   output logic [0:0]    rsp_tuser      // [0] is_stopped
);

   fia_cmd_type cmd;
   fia_sts_type sts;

   logic [31:0] avg_frame_ticks;
   logic [15:0] frame_rate;
   logic [63:0] total_ticks;
   logic        is_stopped;

   // sequencer: one item in flight, walks the mark, window and divide steps
   fia_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // datapath: timestamps, interval window, rate window, divider, result register
   fia_dpath u_dpath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_wr_data         (csr_wr_data),
      .req_func            (req_tuser),
      .req_timestamp       (req_tdata),
      .rsp_tready          (rsp_tready),
      .rsp_tvalid          (rsp_tvalid),
      .rsp_avg_frame_ticks (avg_frame_ticks),
      .rsp_frame_rate      (frame_rate),
      .rsp_total_ticks     (total_ticks),
      .rsp_is_stopped      (is_stopped),
      .cmd                 (cmd),
      .sts                 (sts)
   );

   // pack the result fields, lowest first
   assign rsp_tdata = {total_ticks, frame_rate, avg_frame_ticks};
   assign rsp_tuser = is_stopped;

endmodule
